// File: sv/vlfp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vlfp_pkg
// Shared widths and field positions for the variable-length frame parser.
// ---------------------------------------------------------------------------
package vlfp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned PREFIX_W  = 32;
	localparam int unsigned HEADER_W  = 16;
	localparam int unsigned ID_W      = 14;
	localparam int unsigned LEN_W     = 24;
	localparam int unsigned CNT_W     = 2;

	// m_tdata layout, lowest bit first: prefix, id, length, payload byte
	localparam int unsigned ID_LSB    = PREFIX_W;
	localparam int unsigned LEN_LSB   = ID_LSB + ID_W;
	localparam int unsigned BYTE_LSB  = LEN_LSB + LEN_W;
	localparam int unsigned FIELDS_W  = BYTE_LSB + BYTE_W;
	localparam int unsigned OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;

endpackage : vlfp_pkg
`default_nettype wire

// File: sv/variable_length_frame_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// variable_length_frame_parser
// Splits a byte stream into prefix / header / length / payload frames and
// emits one transaction per payload byte, or one for an empty frame.
// ---------------------------------------------------------------------------
// Channel  Dir  Bits                          Transfer
// s_axis   in   tdata[7:0] stream byte        s_tvalid & s_tready
// m_axis   out  tdata[79:0], tuser, tlast     m_tvalid & m_tready
//
// One byte per cycle while no held result stalls; each accepted byte's result is registered.
// All parsing is a single combinational step from the frame state registers
// into the result register; s_tready drops only while a held result stalls.
// Reset (arst_n low) returns to waiting for a prefix and drops m_tvalid.
// Prefix and non-final length bytes produce no result; a header byte does only when it ends an empty frame.
// ---------------------------------------------------------------------------
module variable_length_frame_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [vlfp_pkg::BYTE_W-1:0]         s_tdata,   // stream_byte
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// prefix_word[31:0], message_id[45:32], payload_length[69:46],
	// payload_byte[77:70], zero pad[79:78]
	output logic [vlfp_pkg::OUT_DATA_W-1:0]          m_tdata,
	output logic                                     m_tuser,   // has_payload
	output logic                                     m_tlast    // frame_last
);
	import vlfp_pkg::*;

	typedef enum logic [2:0] {
		PH_PREFIX  = 3'd0,
		PH_HEADER  = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_PAYLOAD = 3'd3
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [PREFIX_W-1:0]   prefix_q, prefix_d;
	logic [HEADER_W-1:0]   header_q, header_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [LEN_W-1:0]      remain_q, remain_d;

	logic                  res_valid;
	logic                  res_has;
	logic                  res_last;
	logic [BYTE_W-1:0]     res_byte;

	logic                  out_valid_q;
	logic [PREFIX_W-1:0]   out_prefix_q;
	logic [ID_W-1:0]       out_id_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_has_q;
	logic                  out_last_q;

	logic                  s_acc;
	logic [LEN_W-1:0]      len_shifted;
	logic [HEADER_W-1:0]   hdr_shifted;
	logic [LEN_W-1:0]      remain_dec;

	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	assign hdr_shifted = {header_q[HEADER_W-BYTE_W-1:0], s_tdata};
	assign len_shifted = {len_q[LEN_W-BYTE_W-1:0], s_tdata};
	assign remain_dec  = remain_q - LEN_W'(1);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		prefix_d  = prefix_q;
		header_d  = header_q;
		len_d     = len_q;
		remain_d  = remain_q;
		res_valid = 1'b0;
		res_has   = 1'b0;
		res_last  = 1'b0;
		res_byte  = '0;
		case (phase_q)
			PH_HEADER: begin
				header_d = hdr_shifted;
				if (cnt_q == CNT_W'(1)) begin
					cnt_d = '0;
					len_d = '0;
					if (hdr_shifted[1:0] == 2'd0) begin
						// no length field: always an empty frame
						res_valid = 1'b1;
						res_last  = 1'b1;
						phase_d   = PH_PREFIX;
					end else begin
						phase_d = PH_LENGTH;
					end
				end else begin
					cnt_d = CNT_W'(1);
				end
			end
			PH_LENGTH: begin
				len_d = len_shifted;
				if ({1'b0, cnt_q} + 3'd1 >= {1'b0, header_q[1:0]}) begin
					cnt_d = '0;
					if (len_shifted == '0) begin
						res_valid = 1'b1;
						res_last  = 1'b1;
						phase_d   = PH_PREFIX;
					end else begin
						remain_d = len_shifted;
						phase_d  = PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			PH_PAYLOAD: begin
				remain_d  = remain_dec;
				res_valid = 1'b1;
				res_has   = 1'b1;
				res_byte  = s_tdata;
				if (remain_dec == '0) begin
					res_last = 1'b1;
					phase_d  = PH_PREFIX;
					cnt_d    = '0;
				end
			end
			default: begin
				// unused phase codes restart the prefix count
				prefix_d = {prefix_q[PREFIX_W-BYTE_W-1:0], s_tdata};
				if (phase_q == PH_PREFIX && cnt_q == CNT_W'(3)) begin
					cnt_d    = '0;
					header_d = '0;
					phase_d  = PH_HEADER;
				end else begin
					cnt_d   = (phase_q == PH_PREFIX) ? cnt_q + CNT_W'(1) : CNT_W'(1);
					phase_d = PH_PREFIX;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			cnt_q       <= '0;
			prefix_q    <= '0;
			header_q    <= '0;
			len_q       <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				prefix_q    <= prefix_d;
				header_q    <= header_d;
				len_q       <= len_d;
				remain_q    <= remain_d;
				out_valid_q <= res_valid;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc && res_valid) begin
			out_prefix_q <= prefix_d;
			out_id_q     <= header_d[HEADER_W-1:2];
			out_len_q    <= len_d;
			out_byte_q   <= res_byte;
			out_has_q    <= res_has;
			out_last_q   <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W-FIELDS_W)'(0), out_byte_q, out_len_q, out_id_q, out_prefix_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

endmodule : variable_length_frame_parser
`default_nettype wire

// File: sv/vlfp_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vlfp_checker
// Port-level checks for the variable-length frame parser.
// ---------------------------------------------------------------------------
module vlfp_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [vlfp_pkg::BYTE_W-1:0]   s_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [vlfp_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic                          m_tuser,
	input wire logic                          m_tlast
);
	import vlfp_pkg::*;

	// a stalled result transaction stays put
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// with no result pending the input side is never blocked
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// an empty frame is always the last transaction of its frame
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("empty frame not marked last");

	// an empty frame carries zero length and a zero byte
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
		m_tdata[LEN_LSB+LEN_W-1:LEN_LSB] == '0 &&
		m_tdata[BYTE_LSB+BYTE_W-1:BYTE_LSB] == '0)
		else $error("empty frame with nonzero length or byte");

	// a payload transaction never reports a zero length
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[LEN_LSB+LEN_W-1:LEN_LSB] != '0)
		else $error("payload byte with zero length");

endmodule : vlfp_checker

bind variable_length_frame_parser vlfp_checker u_vlfp_checker (.*);
`default_nettype wire
